// ===== design/prrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// prrsa_pkg: shared types and constants of the priority round-robin allocator
// Field widths of the stream and configuration ports, register indexes and
// the one-hot sequencer state.
// ----------------------------------------------------------------------------
package prrsa_pkg;

    // Stream field widths
    localparam int REQ_W       = 64;   // request_matrix
    localparam int MASK_W      = 8;    // grant_mask
    localparam int GRANT_W     = 24;   // grant_inputs
    localparam int OUT_TDATA_W = 32;   // grant_mask + grant_inputs

    // Configuration register widths and reset values
    localparam int PRIO_TBL_W = 32;
    localparam int ACT_W      = 4;
    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
    localparam int ACT_MIN    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS  = 2'd1;

    // Sequencer state
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ===== design/prrsa_pick.sv =====
// ----------------------------------------------------------------------------
// prrsa_pick: per-output winner selection
// Picks, among the free requesting active inputs of one output, the one with
// the lowest priority number; ties go to the first input at or above the
// round-robin pointer, then wrap to the lowest index.
// ----------------------------------------------------------------------------
module prrsa_pick #(
    parameter int NUM_INPUTS = 8,
    parameter int PRIO_BITS  = 4
) (
    input  logic [NUM_INPUTS-1:0]           i_req,
    input  logic [NUM_INPUTS-1:0]           i_free,
    input  logic [NUM_INPUTS*PRIO_BITS-1:0] i_prio,   // input 0 lowest
    input  logic [$clog2(NUM_INPUTS)-1:0]   i_ptr,
    input  logic [$clog2(NUM_INPUTS):0]     i_n_eff,
    output logic                            o_found,
    output logic [$clog2(NUM_INPUTS)-1:0]   o_best
);

    localparam int IDX_BITS = $clog2(NUM_INPUTS);
    localparam int NW       = IDX_BITS + 1;
    localparam int KEY_W    = PRIO_BITS + 1 + IDX_BITS;

    always_comb begin
        logic [KEY_W-1:0]    best_key;
        logic [KEY_W-1:0]    key;
        logic [IDX_BITS-1:0] idx;
        logic                ok;
        best_key = '0;
        o_found  = 1'b0;
        o_best   = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            idx = IDX_BITS'(i);
            ok  = i_req[i] && i_free[i] && (NW'(i) < i_n_eff);
            // priority first, then inputs below the pointer rank last
            key = {i_prio[i*PRIO_BITS +: PRIO_BITS], (idx < i_ptr), idx};
            if (ok && (!o_found || key < best_key)) begin
                o_found  = 1'b1;
                o_best   = idx;
                best_key = key;
            end
        end
    end

endmodule

// ===== design/priority_round_robin_switch_allocator.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_switch_allocator: separable priority round-robin
// switch allocator, one output port arbitrated per cycle
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  s       | in        | i_s_tvalid/o_s_tready  | request_matrix[63:0]
//  m       | out       | o_m_tvalid/i_m_tready  | grant_mask[7:0], grant_inputs
//  cfg     | in        | i_cfg_valid/o_cfg_ready| index, data (write only)
//
// An item passes through the shared picker one output port at a time, since
// each output sees the inputs taken by those before it; the result is valid
// once the last output port has been arbitrated.
// The next item is accepted only after the result has been taken, so the block
// holds one item at a time.
// Reset clears the round-robin pointers, the priority table (to zero) and the
// active count (to eight). No clearing pass is needed.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module priority_round_robin_switch_allocator #(
    parameter int NUM_INPUTS  = 8,
    parameter int NUM_OUTPUTS = 8,
    parameter int PRIO_BITS   = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [prrsa_pkg::REQ_W-1:0]         i_s_tdata,   // [63:0] request_matrix
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [prrsa_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // [7:0] grant_mask,
                                                             // [31:8] grant_inputs
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prrsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prrsa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_BITS = $clog2(NUM_INPUTS);
    localparam int NW       = IDX_BITS + 1;
    localparam int OW       = $clog2(NUM_OUTPUTS);
    localparam int REQ_W    = prrsa_pkg::REQ_W;
    localparam int TBL_W    = prrsa_pkg::PRIO_TBL_W;
    localparam int MASK_W   = prrsa_pkg::MASK_W;
    localparam int GRANT_W  = prrsa_pkg::GRANT_W;
    localparam int ACT_W    = prrsa_pkg::ACT_W;
    localparam int RPW  = (NUM_OUTPUTS*NUM_INPUTS > REQ_W) ? NUM_OUTPUTS*NUM_INPUTS : REQ_W;
    localparam int PPW  = (NUM_INPUTS*PRIO_BITS > TBL_W) ? NUM_INPUTS*PRIO_BITS : TBL_W;
    localparam int GPW  = (NUM_OUTPUTS*IDX_BITS > GRANT_W) ? NUM_OUTPUTS*IDX_BITS : GRANT_W;
    localparam int MPW  = (NUM_OUTPUTS > MASK_W) ? NUM_OUTPUTS : MASK_W;
    localparam int CW   = (ACT_W > NW) ? ACT_W : NW;

    prrsa_pkg::t_state r_state, n_state;

    logic [REQ_W-1:0]       r_req;
    logic [TBL_W-1:0]       r_prio_table;
    logic [ACT_W-1:0]       r_active;
    logic [OW-1:0]          r_out_idx;
    logic [NUM_INPUTS-1:0]  r_taken;
    logic [NUM_OUTPUTS-1:0] r_gvalid;
    logic [IDX_BITS-1:0]    r_gidx [NUM_OUTPUTS];
    logic [IDX_BITS-1:0]    r_ptr  [NUM_OUTPUTS];

    logic s_accept, m_accept, cfg_accept, last_out;
    logic [RPW-1:0]         req_pad;
    logic [NUM_INPUTS-1:0]  req_rows [NUM_OUTPUTS];
    logic [PPW-1:0]         prio_pad;
    logic [CW-1:0]          act_ext;
    logic [NW-1:0]          n_eff;
    logic                   pick_found;
    logic [IDX_BITS-1:0]    pick_best;
    logic [NW-1:0]          best_inc;
    logic [IDX_BITS-1:0]    next_ptr;
    logic [NUM_OUTPUTS*IDX_BITS-1:0] gidx_flat;
    logic [GPW-1:0]         gidx_pad;
    logic [MPW-1:0]         gmask_pad;

    assign o_s_tready  = (r_state == prrsa_pkg::S_IDLE);
    assign o_m_tvalid  = (r_state == prrsa_pkg::S_DONE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign m_accept    = o_m_tvalid && i_m_tready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign last_out    = (r_out_idx == OW'(NUM_OUTPUTS - 1));

    // Request groups beyond the field read as zero
    assign req_pad  = RPW'(r_req);
    assign prio_pad = PPW'(r_prio_table);

    for (genvar o = 0; o < NUM_OUTPUTS; o++) begin : g_rows
        assign req_rows[o] = req_pad[o*NUM_INPUTS +: NUM_INPUTS];
        assign gidx_flat[o*IDX_BITS +: IDX_BITS] = r_gidx[o];
    end

    // Clamp the active count into [2, NUM_INPUTS]
    always_comb begin
        act_ext = CW'(r_active);
        if (act_ext < CW'(prrsa_pkg::ACT_MIN)) begin
            n_eff = NW'(prrsa_pkg::ACT_MIN);
        end else if (act_ext > CW'(NUM_INPUTS)) begin
            n_eff = NW'(NUM_INPUTS);
        end else begin
            n_eff = NW'(act_ext);
        end
    end

    prrsa_pick #(
        .NUM_INPUTS (NUM_INPUTS),
        .PRIO_BITS  (PRIO_BITS)
    ) u_pick (
        .i_req   (req_rows[r_out_idx]),
        .i_free  (~r_taken),
        .i_prio  (prio_pad[NUM_INPUTS*PRIO_BITS-1:0]),
        .i_ptr   (r_ptr[r_out_idx]),
        .i_n_eff (n_eff),
        .o_found (pick_found),
        .o_best  (pick_best)
    );

    // Advance to winner + 1, wrapping at the active count
    assign best_inc = NW'(pick_best) + NW'(1);
    assign next_ptr = (best_inc == n_eff) ? '0 : IDX_BITS'(best_inc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prrsa_pkg::S_IDLE: if (s_accept) n_state = prrsa_pkg::S_RUN;
            prrsa_pkg::S_RUN:  if (last_out) n_state = prrsa_pkg::S_DONE;
            prrsa_pkg::S_DONE: if (m_accept) n_state = prrsa_pkg::S_IDLE;
            default:           n_state = prrsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prrsa_pkg::S_IDLE;
            r_prio_table <= '0;
            r_active     <= prrsa_pkg::ACT_RESET;
            r_out_idx    <= '0;
            r_taken      <= '0;
            r_gvalid     <= '0;
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                r_ptr[o] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    prrsa_pkg::REG_PRIORITY_TABLE: r_prio_table <= i_cfg_data[TBL_W-1:0];
                    prrsa_pkg::REG_ACTIVE_INPUTS:  r_active     <= i_cfg_data[ACT_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_out_idx <= '0;
                r_taken   <= '0;
                r_gvalid  <= '0;
            end else if (r_state == prrsa_pkg::S_RUN) begin
                r_out_idx <= last_out ? '0 : r_out_idx + OW'(1);
                if (pick_found) begin
                    r_taken[pick_best]  <= 1'b1;
                    r_gvalid[r_out_idx] <= 1'b1;
                    r_ptr[r_out_idx]    <= next_ptr;
                end
            end
        end
    end

    // Payload: request word and winner indexes
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req <= i_s_tdata;
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                r_gidx[o] <= '0;
            end
        end else if (r_state == prrsa_pkg::S_RUN && pick_found) begin
            r_gidx[r_out_idx] <= pick_best;
        end
    end

    assign gidx_pad  = GPW'(gidx_flat);
    assign gmask_pad = MPW'(r_gvalid);
    assign o_m_tdata = {gidx_pad[GRANT_W-1:0], gmask_pad[MASK_W-1:0]};

    // Checks
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == prrsa_pkg::S_RUN) && (r_out_idx == '0) && (r_taken == '0))
        else $error("round did not start at output zero with all inputs free");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prrsa_pkg::S_RUN) && last_out |=> o_m_tvalid)
        else $error("result not presented after last output");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_taken) == $countones(r_gvalid))
        else $error("granted inputs and granted outputs differ in count");

    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prrsa_pkg::S_RUN) && pick_found |-> (NW'(pick_best) < n_eff))
        else $error("winner outside the active inputs");

endmodule

// ===== bench/priority_round_robin_switch_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_switch_allocator_test: self-checking bench
// Drives request matrices into the allocator and checks each grant item
// against a local model of the allocator. The model tracks the per-output
// round-robin pointers, the priority table and the active input count.
// Register settings change between phases, only while the block is idle.
// Both stream sides idle at random, and the bench runs one long receiver
// stall and one sender pause.
// ----------------------------------------------------------------------------
module priority_round_robin_switch_allocator_test;

    localparam int N_IN           = 8;
    localparam int N_OUT          = 8;
    localparam int PRIO_W         = 4;
    localparam int IDX_W          = 3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int PHASE_ITEMS    = 92;
    localparam int NUM_PHASES     = 9;

    // Indexes that map to no register
    localparam logic [prrsa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [prrsa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        logic [prrsa_pkg::GRANT_W-1:0] inputs;
        logic [prrsa_pkg::MASK_W-1:0]  mask;
    } t_grant;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [prrsa_pkg::REQ_W-1:0]       i_s_tdata   = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [prrsa_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [prrsa_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [prrsa_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Allocator model state
    logic [IDX_W-1:0]                 rr_ptr [N_OUT];
    logic [prrsa_pkg::PRIO_TBL_W-1:0] prio_tbl = '0;
    logic [prrsa_pkg::ACT_W-1:0]      act_cfg  = prrsa_pkg::ACT_RESET;

    logic [prrsa_pkg::REQ_W-1:0] req_queue [$];
    t_grant                      grants_expected [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_stall_go = 1'b0;
    bit stall_done    = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int errors        = 0;
    int rounds        = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;

    priority_round_robin_switch_allocator #(
        .NUM_INPUTS  (N_IN),
        .NUM_OUTPUTS (N_OUT),
        .PRIO_BITS   (PRIO_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // [63:0] request_matrix
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),     // [7:0] grant_mask, [31:8] grant_inputs
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Append one request matrix to the pending items
    task automatic queue_request(input logic [prrsa_pkg::REQ_W-1:0] req);
        req_queue = {req_queue, req};
    endtask

    // One allocation round of the model: outputs in index order, lowest
    // priority number wins, ties go to the first input at or after the pointer
    task automatic allocate_round(input logic [prrsa_pkg::REQ_W-1:0] req);
        t_grant          g;
        logic [N_IN-1:0] taken;
        int              n, o, i, key, best, best_prio, best_key;
        bit              found;
        g     = '0;
        taken = '0;
        n     = act_cfg;
        if (n < prrsa_pkg::ACT_MIN) n = prrsa_pkg::ACT_MIN;
        if (n > N_IN) n = N_IN;
        for (o = 0; o < N_OUT; o++) begin
            found     = 1'b0;
            best      = 0;
            best_prio = 0;
            best_key  = 0;
            for (i = 0; i < n; i++) begin
                if (!taken[i] && req[o*N_IN + i]) begin
                    key = (i >= rr_ptr[o]) ? i : i + 32;
                    if (!found || prio_tbl[i*PRIO_W +: PRIO_W] < best_prio ||
                        (prio_tbl[i*PRIO_W +: PRIO_W] == best_prio && key < best_key)) begin
                        found     = 1'b1;
                        best      = i;
                        best_prio = prio_tbl[i*PRIO_W +: PRIO_W];
                        best_key  = key;
                    end
                end
            end
            if (found) begin
                taken[best]               = 1'b1;
                g.mask[o]                 = 1'b1;
                g.inputs[o*IDX_W +: IDX_W] = best[IDX_W-1:0];
                rr_ptr[o]                 = IDX_W'((best + 1) % n);
            end
        end
        grants_expected = {grants_expected, g};
    endtask

    task automatic check_grants(input logic [prrsa_pkg::OUT_TDATA_W-1:0] tdata);
        t_grant got, want;
        got = tdata;
        results_seen++;
        if (grants_expected.size() == 0) begin
            $display("%0t: unexpected grant item mask=%h inputs=%h",
                     $time, got.mask, got.inputs);
            errors++;
        end else begin
            want = grants_expected.pop_front();
            if (got.mask !== want.mask) begin
                $display("%0t: grant_mask expected %h actual %h", $time, want.mask, got.mask);
                errors++;
            end
            if (got.inputs !== want.inputs) begin
                $display("%0t: grant_inputs expected %h actual %h",
                         $time, want.inputs, got.inputs);
                errors++;
            end
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                allocate_round(i_s_tdata);
                rounds++;
            end
            // hold the item until it is taken
            if (!i_s_tvalid || o_s_tready) begin
                if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= req_queue.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Grant monitor and receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_grants(o_m_tdata);
            if (long_stall_go && !stall_done) begin
                stall_done <= 1'b1;
                stall_left <= LONG_STALL;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** priority_round_robin_switch_allocator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [prrsa_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [prrsa_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            prrsa_pkg::REG_PRIORITY_TABLE: prio_tbl = data;
            prrsa_pkg::REG_ACTIVE_INPUTS:  act_cfg  = data[prrsa_pkg::ACT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every round has come back, then let the picker settle;
    // sample away from the rising edge so the driver's updates have landed
    task automatic drain();
        do @(negedge i_clk);
        while (req_queue.size() > 0 || i_s_tvalid || grants_expected.size() > 0);
        repeat (N_OUT + 4) @(posedge i_clk);
    endtask

    function automatic logic [prrsa_pkg::REQ_W-1:0] random_requests();
        logic [prrsa_pkg::REQ_W-1:0] r;
        logic [N_IN-1:0]             col;
        int                          o;
        case ($urandom_range(0, 4))
            0: r = {$urandom, $urandom};
            1: r = {$urandom, $urandom} & {$urandom, $urandom};
            2: r = {$urandom, $urandom} | {$urandom, $urandom};
            3: begin
                // every output wants the same inputs
                col = N_IN'($urandom);
                r   = {N_OUT{col}};
            end
            default: begin
                r = '0;
                for (o = 0; o < N_OUT; o++)
                    r[o*N_IN + $urandom_range(0, N_IN-1)] = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [prrsa_pkg::PRIO_TBL_W-1:0] random_priorities(input int k);
        case (k % 3)
            0:       return $urandom;
            1:       return $urandom & 32'h1111_1111;   // two levels, many ties
            default: return {8{4'($urandom)}};          // all equal
        endcase
    endfunction

    initial begin
        logic [prrsa_pkg::ACT_W-1:0] act_plan [NUM_PHASES];
        int                          k, j;
        act_plan = '{4'd15, 4'd0, 4'd1, 4'd3, 4'd5, 4'd2, 4'd7, 4'd9, 4'd8};
        for (k = 0; k < N_OUT; k++)
            rr_ptr[k] = '0;
        send_idle_pct = 10;
        recv_idle_pct = 66;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rounds at reset settings
        queue_request(64'h0);
        queue_request('1);
        queue_request('1);
        queue_request('1);
        queue_request(64'h1);
        queue_request(64'h8000_0000_0000_0000);
        queue_request(64'hFF);
        queue_request(64'h0101_0101_0101_0101);
        queue_request(64'h8080_8080_8080_8080);
        queue_request(64'h8040_2010_0804_0201);
        queue_request(64'h0102_0408_1020_4080);
        queue_request(64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(64'h5555_5555_5555_5555);
        queue_request(64'hFF00_FF00_FF00_FF00);
        queue_request(64'h00FF_00FF_00FF_00FF);
        drain();

        for (k = 0; k < NUM_PHASES; k++) begin
            if (k == 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 10;
            end else if (k == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(prrsa_pkg::REG_PRIORITY_TABLE,
                      k == 0 ? 32'hFFFF_FFFF : random_priorities(k));
            write_reg(prrsa_pkg::REG_ACTIVE_INPUTS, {$urandom} & ~32'hF | act_plan[k]);
            if (k == 0 || k == 4) begin
                write_reg(REG_UNMAPPED_A, $urandom);
                write_reg(REG_UNMAPPED_B, $urandom);
            end
            for (j = 0; j < PHASE_ITEMS; j++) begin
                queue_request(random_requests());
                if (k == 4 && j == PHASE_ITEMS / 2)
                    drain();   // sender pause: nothing offered until all grants are back
            end
            if (k == 1)
                long_stall_go = 1'b1;
            drain();
        end

        $display("Ran %0d allocation rounds, checked %0d grant items, %0d register writes.",
                 rounds, results_seen, cfg_writes);
        $display("Active input counts 0 to 15 with tied, two-level and full-range priorities.");
        if (grants_expected.size() > 0) begin
            $display("%0t: %0d grant items never arrived", $time, grants_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("** priority_round_robin_switch_allocator: PASSED **");
        else
            $display("** priority_round_robin_switch_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/prrsa_pkg.sv
design/prrsa_pick.sv
design/priority_round_robin_switch_allocator.sv
bench/priority_round_robin_switch_allocator_test.sv
